// File: hw/rtl/assert_macros.svh
// Assertion macros shared by the matcher RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define KSBM_ASSERT_IMPL(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define KSBM_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/ksbm_pkg.sv
// Types, codes and default sizes for the key sequence binding matcher.
// No dependencies.
package ksbm_pkg;

    localparam int NUM_BINDINGS_DEF = 16;
    localparam int MAX_SEQ_LEN_DEF  = 8;

    localparam int CHAR_W     = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 64;
    localparam int ALLOW_W    = 127;

    localparam logic [7:0] KEY_IGNORE = 8'd127;

    typedef enum logic [1:0] {
        CMD_KEY     = 2'd0,
        CMD_WR_CHAR = 2'd1,
        CMD_WR_LEN  = 2'd2,
        CMD_NOP     = 2'd3
    } cmd_e;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ALLOW_LO = 2'd0,
        REG_ALLOW_HI = 2'd1,
        REG_COUNT    = 2'd2,
        REG_NONE     = 2'd3
    } reg_idx_e;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_SCAN,
        ST_DRAIN,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] key_code;
        logic [3:0] slot_index;
        logic [2:0] char_position;
        logic [6:0] binding_char;
        logic [3:0] binding_length;
    } in_item_t;

    typedef struct packed {
        logic       matched;
        logic [3:0] matched_index;
        logic       sequence_cleared;
        logic [3:0] sequence_length;
    } out_item_t;

    typedef struct packed {
        logic capture;
        logic dispatch;
        logic scan_init;
        logic scan_issue;
        logic commit;
    } dp_cmd_t;

    typedef struct packed {
        logic is_key;
        logic n_zero;
        logic scan_last;
    } dp_status_t;

endpackage

// File: hw/rtl/ksbm_ctrl.sv
// Sequencer for the matcher: accept, table write or binding scan, result hand-off.
// Depends on ksbm_pkg.
module ksbm_ctrl
    import ksbm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       item_valid,
    output logic       item_ready,
    output logic       result_valid,
    input  logic       result_ready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        item_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                item_ready = 1'b1;
                if (item_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                cmd.dispatch = 1'b1;
                if (status.is_key)
                begin
                    cmd.scan_init = 1'b1;
                    state_next    = status.n_zero ? ST_FINISH : ST_SCAN;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_SCAN:
            begin
                cmd.scan_issue = 1'b1;
                if (status.scan_last)
                    state_next = ST_DRAIN;
            end
            ST_DRAIN:
            begin
                // last compare lands this cycle
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || result_ready)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.commit)
            out_valid_next = 1'b1;
        else if (result_ready)
            out_valid_next = 1'b0;
    end

    assign result_valid = out_valid_reg;

endmodule

// File: hw/rtl/ksbm_dp.sv
// Datapath: config registers, binding table memories, held sequence,
// per-slot compare stage and result register. Depends on ksbm_pkg.
module ksbm_dp
    import ksbm_pkg::*;
#(
    parameter int NUM_BINDINGS = NUM_BINDINGS_DEF,
    parameter int MAX_SEQ_LEN  = MAX_SEQ_LEN_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  in_item_t              item,
    output out_item_t             result,
    input  dp_cmd_t               cmd,
    output dp_status_t            status
);

    localparam int SW   = (NUM_BINDINGS > 1) ? $clog2(NUM_BINDINGS) : 1;
    localparam int CW   = $clog2(NUM_BINDINGS + 1);
    localparam int PW   = (MAX_SEQ_LEN > 1) ? $clog2(MAX_SEQ_LEN) : 1;
    localparam int LW   = $clog2(MAX_SEQ_LEN + 1);
    localparam int LENW = $clog2(MAX_SEQ_LEN + 2);

    // configuration
    logic [63:0] allow_lo_reg;
    logic [62:0] allow_hi_reg;
    logic [4:0]  count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            allow_lo_reg <= '0;
            allow_hi_reg <= '0;
            count_reg    <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_ALLOW_LO: allow_lo_reg <= cfg_data;
                REG_ALLOW_HI: allow_hi_reg <= cfg_data[62:0];
                REG_COUNT:    count_reg    <= cfg_data[4:0];
                REG_NONE:     ;
            endcase
        end
    end

    // captured item
    in_item_t item_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
            item_reg <= item;
    end

    logic [CHAR_W-1:0]  key7;
    logic [ALLOW_W-1:0] allow_vec;
    logic               is_key;
    logic               append;
    logic [CW-1:0]      n_use;
    logic [LW-1:0]      cnt_reg;
    logic [LENW-1:0]    len_w;

    assign key7      = item_reg.key_code[6:0];
    assign allow_vec = {allow_hi_reg, allow_lo_reg};
    assign is_key    = (item_reg.cmd == CMD_KEY) && (item_reg.key_code < KEY_IGNORE);
    assign append    = (key7 != '0) && (key7 != KEY_IGNORE[6:0]) && allow_vec[key7];
    assign n_use     = (7'(count_reg) > 7'(NUM_BINDINGS)) ? CW'(NUM_BINDINGS) : CW'(count_reg);
    assign len_w     = LENW'(cnt_reg) + LENW'(append);

    // binding table
    logic [MAX_SEQ_LEN-1:0][CHAR_W-1:0] bchar_mem [NUM_BINDINGS];
    logic [LW-1:0]                      blen_mem  [NUM_BINDINGS];

    logic [SW-1:0]   wr_slot;
    logic [PW-1:0]   wr_pos;
    logic [LW-1:0]   wr_len;
    logic            slot_ok;
    logic            pos_ok;

    assign wr_slot = SW'(item_reg.slot_index);
    assign wr_pos  = PW'(item_reg.char_position);
    assign slot_ok = 7'(item_reg.slot_index) < 7'(NUM_BINDINGS);
    assign pos_ok  = 6'(item_reg.char_position) < 6'(MAX_SEQ_LEN);
    assign wr_len  = (6'(item_reg.binding_length) > 6'(MAX_SEQ_LEN)) ?
                     LW'(MAX_SEQ_LEN) : LW'(item_reg.binding_length);

    always_ff @(posedge clk)
    begin
        if (cmd.dispatch && item_reg.cmd == CMD_WR_CHAR && slot_ok && pos_ok)
            bchar_mem[wr_slot][wr_pos] <= item_reg.binding_char;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.dispatch && item_reg.cmd == CMD_WR_LEN && slot_ok)
            blen_mem[wr_slot] <= wr_len;
    end

    // scan: read slot idx, compare it in the next cycle
    logic [CW-1:0]                      idx_reg;
    logic [SW-1:0]                      raddr;
    logic [MAX_SEQ_LEN-1:0][CHAR_W-1:0] row_q;
    logic [LW-1:0]                      blen_q;
    logic [SW-1:0]                      cmp_idx_reg;
    logic                               rd_vld_reg;

    assign raddr = SW'(idx_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.scan_issue)
        begin
            row_q       <= bchar_mem[raddr];
            blen_q      <= blen_mem[raddr];
            cmp_idx_reg <= raddr;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            rd_vld_reg <= cmd.scan_issue;
            if (cmd.scan_init)
                idx_reg <= '0;
            else if (cmd.scan_issue)
                idx_reg <= idx_reg + CW'(1);
        end
    end

    // held sequence with the new key laid over its append position
    logic [MAX_SEQ_LEN-1:0][CHAR_W-1:0] seq_reg;
    logic                               same;
    logic [LENW-1:0]                    blen_ext;

    assign blen_ext = LENW'(blen_q);

    always_comb
    begin
        logic [CHAR_W-1:0] cand;
        same = 1'b1;
        for (int j = 0; j < MAX_SEQ_LEN; j++)
        begin
            cand = (append && j == int'(cnt_reg)) ? key7 : seq_reg[j];
            if (j < int'(len_w) && cand != row_q[j])
                same = 1'b0;
        end
    end

    logic [LW-1:0] maxlen_reg;
    logic          found_reg;
    logic [SW-1:0] found_idx_reg;
    logic          prefix_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            maxlen_reg    <= '0;
            found_reg     <= 1'b0;
            found_idx_reg <= '0;
            prefix_reg    <= 1'b0;
        end
        else if (cmd.scan_init)
        begin
            maxlen_reg <= '0;
            found_reg  <= 1'b0;
            prefix_reg <= 1'b0;
        end
        else if (rd_vld_reg)
        begin
            if (blen_q > maxlen_reg)
                maxlen_reg <= blen_q;
            if (same && blen_ext == len_w && !found_reg)
            begin
                found_reg     <= 1'b1;
                found_idx_reg <= cmp_idx_reg;
            end
            if (same && blen_ext > len_w)
                prefix_reg <= 1'b1;
        end
    end

    // commit
    logic      over;
    logic      keep;
    out_item_t res;
    logic [LW-1:0] cnt_next;

    assign over = len_w > LENW'(maxlen_reg);
    assign keep = !over && !found_reg && prefix_reg;

    always_comb
    begin
        res      = '0;
        cnt_next = cnt_reg;
        if (is_key)
        begin
            cnt_next = keep ? LW'(len_w) : '0;
            res.sequence_cleared = !keep;
            if (!over && found_reg)
            begin
                res.matched       = 1'b1;
                res.matched_index = 4'(found_idx_reg);
            end
        end
        res.sequence_length = 4'(cnt_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else if (cmd.commit)
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit && is_key && append && !over)
            seq_reg[PW'(cnt_reg)] <= key7;
    end

    out_item_t out_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
            out_reg <= res;
    end

    assign result           = out_reg;
    assign status.is_key    = is_key;
    assign status.n_zero    = (n_use == '0);
    assign status.scan_last = (idx_reg == n_use - CW'(1));

endmodule

// File: hw/rtl/key_sequence_binding_matcher_core.sv
// Top level of the key sequence binding matcher: controller plus datapath.
// Depends on ksbm_pkg, ksbm_ctrl, ksbm_dp and assert_macros.svh.
//
//  channel  | handshake                   | payload
//  ---------+-----------------------------+---------------------------
//  item     | item_valid / item_ready     | item   (in_item_t)
//  result   | result_valid / result_ready | result (out_item_t)
//  config   | cfg_we, no wait             | cfg_index, cfg_data
//
// A key item goes through accept, dispatch, a scan of the n slots in use, drain and
// finish before its result is shown; with no slot in use scan and drain are skipped.
// The scan reads one slot per cycle through the binding table read port.
// Table writes and other commands go through accept, dispatch and finish.
// One item is in work at a time; the next is accepted while a result waits.
// A result stalled on result_ready holds the finish step of the next item.
// Reset clears config, held length and control; the table is undefined until written.
`include "assert_macros.svh"

module key_sequence_binding_matcher_core
    import ksbm_pkg::*;
#(
    parameter int NUM_BINDINGS = NUM_BINDINGS_DEF,
    parameter int MAX_SEQ_LEN  = MAX_SEQ_LEN_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    output logic                  item_ready,
    input  in_item_t              item,
    output logic                  result_valid,
    input  logic                  result_ready,
    output out_item_t             result,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    dp_cmd_t    cmd;
    dp_status_t status;

    ksbm_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .status       (status),
        .cmd          (cmd)
    );

    ksbm_dp #(
        .NUM_BINDINGS (NUM_BINDINGS),
        .MAX_SEQ_LEN  (MAX_SEQ_LEN)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .item      (item),
        .result    (result),
        .cmd       (cmd),
        .status    (status)
    );

    `KSBM_ASSERT_IMPL(a_commit_free, cmd.commit, !result_valid || result_ready, "result overwritten")
    `KSBM_ASSERT_NEXT(a_busy_after_accept, item_valid && item_ready, !item_ready, "second accept")
    `KSBM_ASSERT_IMPL(a_scan_needs_slots, cmd.scan_issue, !status.n_zero, "scan with no slots")
    `KSBM_ASSERT_NEXT(a_commit_shows, cmd.commit, result_valid, "result not shown")

endmodule
